[src/nes_pkg.sv]
// Shared types and constants of the NFA epsilon closure stepper.
`timescale 1ns / 1ps
package nes_pkg;

  // Fixed field widths of the command and result transfers
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STATE_W = 6;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SYM_W   = 9;
  localparam int unsigned NADR_W  = 32;
  localparam int unsigned ACT_W   = 64;

  // Parameter defaults
  localparam int unsigned NUM_STATES_DEF  = 64;
  localparam int unsigned SYMBOL_BITS_DEF = 9;
  localparam int unsigned ADDR_BITS_DEF   = 32;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_EDGE    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADDR    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STEP    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd4;

  // Edge labels
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EPS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SYM  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [STATE_W-1:0] src_state;
    logic [STATE_W-1:0] dst_state;
    logic [KIND_W-1:0]  edge_kind;
    logic [SYM_W-1:0]   symbol;
    logic [NADR_W-1:0]  node_address;
    logic               has_address;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0]  active_states;
    logic [NADR_W-1:0] address;
    logic              address_valid;
    logic              last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EW_RD,
    ST_EW_WR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FIND
  } state_e;

  typedef enum logic [1:0] {
    MODE_FWD,
    MODE_BWD,
    MODE_STEP,
    MODE_HIT
  } mode_e;

endpackage

[src/nes_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module nes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/nes_cell.sv]
// One state cell: edge decode for its column, node address, min-search chain stage.
`timescale 1ns / 1ps
module nes_cell import nes_pkg::*; #(
  parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int unsigned ADDR_BITS   = ADDR_BITS_DEF,
  parameter int unsigned SW          = 6,
  parameter int unsigned IDX         = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [KIND_W+SYMBOL_BITS-1:0] entry_i,
  input  logic [SYMBOL_BITS-1:0]      sym_i,
  output logic                        eps_o,
  output logic                        sym_o,
  input  logic                        nwr_i,
  input  logic [SW-1:0]               nwr_idx_i,
  input  logic                        nwr_valid_i,
  input  logic [ADDR_BITS-1:0]        nwr_addr_i,
  input  logic                        hit_i,
  input  logic                        have_thr_i,
  input  logic [ADDR_BITS-1:0]        thr_i,
  input  logic                        found_i,
  input  logic [ADDR_BITS-1:0]        best_i,
  output logic                        found_o,
  output logic [ADDR_BITS-1:0]        best_o
);

  logic [KIND_W-1:0]      kind;
  logic                   av_q;
  logic [ADDR_BITS-1:0]   addr_q;
  logic                   cand;
  logic                   found_q;
  logic [ADDR_BITS-1:0]   best_q;

  // Edge label decode for this target column
  assign kind  = entry_i[SYMBOL_BITS +: KIND_W];
  assign eps_o = (kind == KIND_EPS);
  assign sym_o = (kind == KIND_SYM) && (entry_i[SYMBOL_BITS-1:0] == sym_i);

  // Node address storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
    end else if (nwr_i && (nwr_idx_i == SW'(IDX))) begin
      av_q <= nwr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nwr_i && (nwr_idx_i == SW'(IDX))) begin
      addr_q <= nwr_valid_i ? nwr_addr_i : '0;
    end
  end

  // Chain stage: smallest address above the threshold seen so far
  assign cand = hit_i && av_q && (!have_thr_i || (addr_q > thr_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_i || cand;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= (cand && (!found_i || (addr_q < best_i))) ? addr_q : best_i;
  end

  assign found_o = found_q;
  assign best_o  = best_q;

endmodule

[src/nfa_epsilon_closure_stepper_top.sv]
// Top level of the NFA epsilon closure stepper: sequencer, edge row RAM, cell row.
// Sequence: an edge write reads the source row, then writes it back merged; an address
// write or an unused code just returns its result; restart, step and query run row scans
// pass after pass until the set stops growing, and a query then runs the min-search chain once per address.
// Throughput: one command at a time; busy_o is high while a command runs and is low again when its last result is out.
// Reset: asynchronous, active low; active set, start state, row valid bits and node
// address valid bits clear at once, so no clearing pass is needed.
`timescale 1ns / 1ps
module nfa_epsilon_closure_stepper_top import nes_pkg::*; #(
  parameter int unsigned NUM_STATES  = NUM_STATES_DEF,
  parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int unsigned ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  cmd_t               cmd_i,
  input  logic               cfg_we_i,
  input  logic [STATE_W-1:0] cfg_wdata_i,
  output logic               res_valid_o,
  output res_t               res_o
);

  localparam int unsigned N   = NUM_STATES;
  localparam int unsigned SW  = $clog2(N);
  localparam int unsigned CW  = $clog2(N + 1);
  localparam int unsigned EW  = KIND_W + SYMBOL_BITS;
  localparam int unsigned RW  = N * EW;

  state_e               state_q, state_d;
  mode_e                mode_q, mode_d;
  cmd_t                 cmd_q;
  logic [SW-1:0]        idx_q, idx_d;
  logic [N-1:0]         work_q, work_d;
  logic                 chg_q, chg_d;
  logic [N-1:0]         active_q, active_d;
  logic [STATE_W-1:0]   start_q;
  logic [N-1:0]         row_vld_q;
  logic [ADDR_BITS-1:0] prev_q, prev_d;
  logic                 have_prev_q, have_prev_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [ADDR_BITS-1:0] pend_q, pend_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 res_vld_q, res_vld_d;
  res_t                 res_q, res_d;

  logic                 accept;
  logic [SYMBOL_BITS-1:0] qsym;
  logic [SW-1:0]        src_i, dst_i, row_sel;
  logic                 edge_ok;
  logic                 ram_we;
  logic [SW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata, row_m, row_new;
  logic [EW-1:0]        new_entry;
  logic [KIND_W-1:0]    new_kind;
  logic [N-1:0]         eps_v, sym_v;
  logic [N-1:0]         scan_nw;
  logic                 scan_ch, pass_end, pass_chg, search_done;
  logic                 nwr;
  logic                 fnd_w [N];
  logic [ADDR_BITS-1:0] bst_w [N];
  res_t                 res_plain;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign qsym    = SYMBOL_BITS'(cmd_q.symbol);
  assign src_i   = SW'(cmd_q.src_state);
  assign dst_i   = SW'(cmd_q.dst_state);
  assign edge_ok = (int'(cmd_q.src_state) < N) && (int'(cmd_q.dst_state) < N);

  // Edge rows: one word per source state
  assign ram_raddr = (state_q == ST_EW_RD) ? src_i : idx_q;
  assign ram_we    = (state_q == ST_EW_WR) && edge_ok;

  nes_ram #(
    .WIDTH (RW),
    .DEPTH (N)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (src_i),
    .wdata_i (row_new),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A row never written reads as all no-edge
  assign row_sel = (state_q == ST_EW_WR) ? src_i : idx_q;
  assign row_m   = row_vld_q[row_sel] ? ram_rdata : '0;

  // Merged row for an edge write
  assign new_kind  = (cmd_q.edge_kind == KIND_EPS || cmd_q.edge_kind == KIND_SYM) ?
                     cmd_q.edge_kind : KIND_NONE;
  assign new_entry = {new_kind, (cmd_q.edge_kind == KIND_SYM) ? qsym : '0};

  always_comb begin
    row_new = row_m;
    row_new[dst_i*EW +: EW] = new_entry;
  end

  // Node address writes go straight to the cells
  assign nwr = accept && (cmd_i.func == FUNC_ADDR) && (int'(cmd_i.src_state) < N);

  // Row of state cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    nes_cell #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .ADDR_BITS   (ADDR_BITS),
      .SW          (SW),
      .IDX         (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .entry_i     (row_m[i*EW +: EW]),
      .sym_i       (qsym),
      .eps_o       (eps_v[i]),
      .sym_o       (sym_v[i]),
      .nwr_i       (nwr),
      .nwr_idx_i   (SW'(cmd_i.src_state)),
      .nwr_valid_i (cmd_i.has_address),
      .nwr_addr_i  (ADDR_BITS'(cmd_i.node_address)),
      .hit_i       (work_q[i]),
      .have_thr_i  (have_prev_q),
      .thr_i       (prev_q),
      .found_i     ((i == 0) ? 1'b0 : fnd_w[(i == 0) ? 0 : i-1]),
      .best_i      ((i == 0) ? '0 : bst_w[(i == 0) ? 0 : i-1]),
      .found_o     (fnd_w[i]),
      .best_o      (bst_w[i])
    );
  end

  // Per-row evaluation of the current scan
  always_comb begin
    scan_nw = work_q;
    unique case (mode_q)
      MODE_FWD: begin
        if (work_q[idx_q]) scan_nw = work_q | eps_v;
      end
      MODE_BWD: begin
        if (!work_q[idx_q] && |(eps_v & work_q)) scan_nw[idx_q] = 1'b1;
      end
      MODE_STEP: begin
        if (active_q[idx_q]) scan_nw = work_q | sym_v;
      end
      MODE_HIT: begin
        if (active_q[idx_q] && |sym_v) scan_nw[idx_q] = 1'b1;
      end
      default: scan_nw = work_q;
    endcase
  end

  assign scan_ch     = (scan_nw != work_q);
  assign pass_end    = (idx_q == SW'(N - 1));
  assign pass_chg    = chg_q || scan_ch;
  assign search_done = (cnt_q == CW'(N));

  assign res_plain = '{active_states: ACT_W'(active_q), address: '0,
                       address_valid: 1'b0, last: 1'b1};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          priority case (cmd_i.func)
            FUNC_EDGE:                           state_d = ST_EW_RD;
            FUNC_RESTART, FUNC_STEP, FUNC_QUERY: state_d = ST_SCAN_RD;
            default:                             state_d = ST_IDLE;
          endcase
        end
      end
      ST_EW_RD:   state_d = ST_EW_WR;
      ST_EW_WR:   state_d = ST_IDLE;
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!pass_end) begin
          state_d = ST_SCAN_RD;
        end else if (mode_q == MODE_FWD && !pass_chg) begin
          state_d = ST_IDLE;
        end else if (mode_q == MODE_BWD && !pass_chg) begin
          state_d = ST_FIND;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_FIND: begin
        if (search_done && !fnd_w[N-1]) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    mode_d      = mode_q;
    idx_d       = idx_q;
    work_d      = work_q;
    chg_d       = chg_q;
    active_d    = active_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    res_vld_d   = 1'b0;
    res_d       = res_plain;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        chg_d = 1'b0;
        if (start_i) begin
          priority case (cmd_i.func)
            FUNC_EDGE: ;
            FUNC_RESTART: begin
              mode_d = MODE_FWD;
              work_d = '0;
              if (int'(start_q) < N) work_d[SW'(start_q)] = 1'b1;
            end
            FUNC_STEP: begin
              mode_d = MODE_STEP;
              work_d = '0;
            end
            FUNC_QUERY: begin
              mode_d = MODE_HIT;
              work_d = '0;
            end
            default: res_vld_d = 1'b1;
          endcase
        end
      end
      ST_EW_RD: ;
      ST_EW_WR: res_vld_d = 1'b1;
      ST_SCAN_RD: ;
      ST_SCAN_EV: begin
        work_d = scan_nw;
        idx_d  = idx_q + SW'(1);
        chg_d  = pass_chg;
        if (pass_end) begin
          idx_d = '0;
          chg_d = 1'b0;
          unique case (mode_q)
            MODE_STEP: mode_d = MODE_FWD;
            MODE_HIT:  mode_d = MODE_BWD;
            MODE_FWD: begin
              if (!pass_chg) begin
                active_d  = scan_nw;
                res_vld_d = 1'b1;
                res_d.active_states = ACT_W'(scan_nw);
              end
            end
            MODE_BWD: begin
              if (!pass_chg) begin
                have_prev_d = 1'b0;
                pend_vld_d  = 1'b0;
                cnt_d       = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        cnt_d = cnt_q + CW'(1);
        if (search_done) begin
          if (fnd_w[N-1]) begin
            res_vld_d           = pend_vld_q;
            res_d.address       = NADR_W'(pend_q);
            res_d.address_valid = 1'b1;
            res_d.last          = 1'b0;
            pend_vld_d          = 1'b1;
            pend_d              = bst_w[N-1];
            prev_d              = bst_w[N-1];
            have_prev_d         = 1'b1;
            cnt_d               = '0;
          end else begin
            res_vld_d = 1'b1;
            if (pend_vld_q) begin
              res_d.address       = NADR_W'(pend_q);
              res_d.address_valid = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_FWD;
      idx_q       <= '0;
      chg_q       <= 1'b0;
      active_q    <= '0;
      start_q     <= '0;
      row_vld_q   <= '0;
      have_prev_q <= 1'b0;
      pend_vld_q  <= 1'b0;
      cnt_q       <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      chg_q       <= chg_d;
      active_q    <= active_d;
      have_prev_q <= have_prev_d;
      pend_vld_q  <= pend_vld_d;
      cnt_q       <= cnt_d;
      res_vld_q   <= res_vld_d;
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (ram_we) row_vld_q[src_i] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_i;
    work_q <= work_d;
    prev_q <= prev_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // A result without an address always closes its command
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.address_valid |-> res_o.last)
    else $error("result without address not marked last");

  // The closing result comes when the sequencer is back at rest
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy_o)
    else $error("last result while still busy");

  // Intermediate query results only while the search is running
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o && res_o.address_valid)
    else $error("intermediate result outside a query");
`endif

endmodule

[dv/tb_nfa_epsilon_closure_stepper_top.sv]
// Self-checking testbench for the NFA epsilon closure stepper top level.
`timescale 1ns / 1ps
module tb_nfa_epsilon_closure_stepper_top;
  import nes_pkg::*;

  localparam int unsigned NST = NUM_STATES_DEF;
  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_MID   = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
  localparam logic [KIND_W-1:0] KIND_RSVD        = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  // Automaton predictor plus queue of expected result transfers
  class closure_board;
    logic [STATE_W-1:0] start_reg;
    logic [ACT_W-1:0]   act_set;
    logic [KIND_W-1:0]  ekind [NST][NST];
    logic [SYM_W-1:0]   esym  [NST][NST];
    logic [NADR_W-1:0]  naddr [NST];
    logic               nval  [NST];
    res_t               pending[$];
    int                 errors;
    int                 n_cmds;
    int                 n_res;
    int                 n_addr_res;

    function new();
      start_reg = '0;
      act_set   = '0;
      errors    = 0;
      n_cmds    = 0;
      n_res     = 0;
      n_addr_res = 0;
      for (int s = 0; s < NST; s++) begin
        naddr[s] = '0;
        nval[s]  = 1'b0;
        for (int t = 0; t < NST; t++) begin
          ekind[s][t] = KIND_NONE;
          esym[s][t]  = '0;
        end
      end
    endfunction

    function logic [ACT_W-1:0] eps_close(logic [ACT_W-1:0] set, bit backward);
      logic [ACT_W-1:0] prev;
      do begin
        prev = set;
        for (int a = 0; a < NST; a++) begin
          if (!prev[a]) continue;
          for (int b = 0; b < NST; b++) begin
            // forward: a -> b; backward: b -> a
            if (!backward && ekind[a][b] == KIND_EPS) set[b] = 1'b1;
            if (backward && ekind[b][a] == KIND_EPS) set[b] = 1'b1;
          end
        end
      end while (set != prev);
      return set;
    endfunction

    function void push_res(logic [NADR_W-1:0] adr, logic av, logic lst);
      res_t r;
      r.active_states = act_set;
      r.address       = adr;
      r.address_valid = av;
      r.last          = lst;
      pending.push_back(r);
    endfunction

    // Called on every accepted command transfer
    function void note_cmd(cmd_t c);
      logic [ACT_W-1:0]  nxt;
      logic [NADR_W-1:0] prev_a, best;
      bit                have_prev, found;
      int                cnt;
      n_cmds++;
      case (c.func)
        FUNC_EDGE: begin
          ekind[c.src_state][c.dst_state] = (c.edge_kind == KIND_RSVD) ? KIND_NONE : c.edge_kind;
          esym[c.src_state][c.dst_state]  = (c.edge_kind == KIND_SYM) ? c.symbol : '0;
        end
        FUNC_ADDR: begin
          nval[c.src_state]  = c.has_address;
          naddr[c.src_state] = c.has_address ? c.node_address : '0;
        end
        FUNC_RESTART: begin
          nxt = '0;
          nxt[start_reg] = 1'b1;
          act_set = eps_close(nxt, 1'b0);
        end
        FUNC_STEP: begin
          nxt = '0;
          for (int s = 0; s < NST; s++)
            if (act_set[s])
              for (int t = 0; t < NST; t++)
                if (ekind[s][t] == KIND_SYM && esym[s][t] == c.symbol) nxt[t] = 1'b1;
          act_set = eps_close(nxt, 1'b0);
        end
        FUNC_QUERY: begin
          nxt = '0;
          for (int s = 0; s < NST; s++)
            if (act_set[s])
              for (int t = 0; t < NST; t++)
                if (ekind[s][t] == KIND_SYM && esym[s][t] == c.symbol) nxt[s] = 1'b1;
          nxt = eps_close(nxt, 1'b1);
          have_prev = 0;
          prev_a = '0;
          cnt = 0;
          // distinct addresses in ascending order
          do begin
            found = 0;
            best = '0;
            for (int s = 0; s < NST; s++) begin
              if (!nxt[s] || !nval[s]) continue;
              if (have_prev && naddr[s] <= prev_a) continue;
              if (!found || naddr[s] < best) begin
                best = naddr[s];
                found = 1;
              end
            end
            if (found) begin
              push_res(best, 1'b1, 1'b0);
              prev_a = best;
              have_prev = 1;
              cnt++;
            end
          end while (found);
          if (cnt > 0) begin
            pending[pending.size()-1].last = 1'b1;
            return;
          end
        end
        default: ;
      endcase
      push_res('0, 1'b0, 1'b1);
    endfunction

    // Called on every result transfer
    function void check_res(res_t r);
      res_t e;
      n_res++;
      if (r.address_valid) n_addr_res++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result act=%h adr=%h av=%b last=%b", $time,
                 r.active_states, r.address, r.address_valid, r.last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.active_states !== e.active_states) begin
        $display("%0t: active_states exp %h got %h", $time, e.active_states, r.active_states);
        errors++;
      end
      if (r.address !== e.address) begin
        $display("%0t: address exp %h got %h", $time, e.address, r.address);
        errors++;
      end
      if (r.address_valid !== e.address_valid) begin
        $display("%0t: address_valid exp %b got %b", $time, e.address_valid, r.address_valid);
        errors++;
      end
      if (r.last !== e.last) begin
        $display("%0t: last exp %b got %b", $time, e.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  cmd_t               cmd_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [STATE_W-1:0] cfg_wdata_i = '0;
  logic               res_valid_o;
  res_t               res_o;

  closure_board board = new();
  int unsigned cycles = 0;

  // Per-phase pools keep the random automaton small
  logic [STATE_W-1:0] st_pool  [8];
  logic [SYM_W-1:0]   sym_pool [4];
  logic [NADR_W-1:0]  adr_pool [4];

  always #5 clk_i = ~clk_i;

  nfa_epsilon_closure_stepper_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Results are held one cycle; sample mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o) board.check_res(res_o);
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Issue one command; start stays high across back-to-back transfers
  task automatic send_cmd(cmd_t c);
    int  gap;
    bit  was_busy;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    forever begin
      @(negedge clk_i);
      was_busy = busy_o;
      @(posedge clk_i);
      if (!was_busy) break;
    end
    board.note_cmd(c);
  endtask

  // Wait until every expected result is in and the block is idle
  task automatic drain();
    bit b;
    start_i <= 1'b0;
    do begin
      @(negedge clk_i);
      b = busy_o;
    end while (board.pending.size() != 0 || b);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start(logic [STATE_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.start_reg = v;
  endtask

  function automatic cmd_t mk(logic [FUNC_W-1:0] f, int s, int d, logic [KIND_W-1:0] k,
                              int sy, logic [NADR_W-1:0] a, logic h);
    cmd_t c;
    c.func = f;
    c.src_state = STATE_W'(s);
    c.dst_state = STATE_W'(d);
    c.edge_kind = k;
    c.symbol = SYM_W'(sy);
    c.node_address = a;
    c.has_address = h;
    return c;
  endfunction

  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(0, 9) == 0) return STATE_W'($urandom_range(0, NST - 1));
    return st_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 9) == 0) return SYM_W'($urandom_range(0, 511));
    return sym_pool[$urandom_range(0, 3)];
  endfunction

  // Mostly well-formed automaton traffic, some noise
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned r;
    c = cmd_t'(CMD_W'({$urandom, $urandom}));
    c.src_state = pick_state();
    c.dst_state = pick_state();
    c.symbol    = pick_sym();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      c.func = FUNC_EDGE;
      r = $urandom_range(0, 19);
      c.edge_kind = (r < 6) ? KIND_EPS : (r < 16) ? KIND_SYM : (r < 19) ? KIND_NONE : KIND_RSVD;
    end else if (r < 45) begin
      c.func = FUNC_ADDR;
      c.has_address = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 1)) c.node_address = adr_pool[$urandom_range(0, 3)];
    end else if (r < 55) begin
      c.func = FUNC_RESTART;
    end else if (r < 78) begin
      c.func = FUNC_STEP;
    end else if (r < 96) begin
      c.func = FUNC_QUERY;
    end else begin
      c.func = FUNC_W'(FUNC_SPARE_FIRST + $urandom_range(0, 2));
    end
    return c;
  endfunction

  initial begin
    logic [STATE_W-1:0] st;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every code, reserved kind, spare codes
    write_start('0);
    send_cmd(mk(FUNC_EDGE, 0, 1, KIND_EPS, 0, '0, 1'b0));
    send_cmd(mk(FUNC_EDGE, 1, 63, KIND_SYM, 511, '0, 1'b0));
    send_cmd(mk(FUNC_EDGE, 63, 0, KIND_SYM, 0, '0, 1'b0));
    send_cmd(mk(FUNC_EDGE, 63, 62, KIND_EPS, 0, '0, 1'b0));
    send_cmd(mk(FUNC_EDGE, 5, 6, KIND_RSVD, 511, '0, 1'b0));
    send_cmd(mk(FUNC_ADDR, 0, 0, KIND_NONE, 0, 32'hFFFF_FFFF, 1'b1));
    send_cmd(mk(FUNC_ADDR, 63, 63, KIND_NONE, 0, 32'h0, 1'b1));
    send_cmd(mk(FUNC_ADDR, 1, 0, KIND_NONE, 0, 32'h5, 1'b1));
    send_cmd(mk(FUNC_ADDR, 62, 0, KIND_NONE, 0, 32'h5, 1'b1));
    send_cmd(mk(FUNC_QUERY, 0, 0, KIND_NONE, 511, '0, 1'b0));
    send_cmd(mk(FUNC_RESTART, 0, 0, KIND_NONE, 0, '0, 1'b0));
    send_cmd(mk(FUNC_QUERY, 0, 0, KIND_NONE, 511, '0, 1'b0));
    send_cmd(mk(FUNC_STEP, 0, 0, KIND_NONE, 511, '0, 1'b0));
    send_cmd(mk(FUNC_QUERY, 0, 0, KIND_NONE, 0, '0, 1'b0));
    send_cmd(mk(FUNC_STEP, 0, 0, KIND_NONE, 0, '0, 1'b0));
    send_cmd(mk(FUNC_ADDR, 1, 0, KIND_NONE, 0, 32'h7, 1'b0));
    send_cmd(mk(FUNC_STEP, 0, 0, KIND_NONE, 77, '0, 1'b0));
    send_cmd(mk(FUNC_SPARE_FIRST, 63, 63, KIND_RSVD, 511, 32'hFFFF_FFFF, 1'b1));
    send_cmd(mk(FUNC_SPARE_MID, 0, 0, KIND_NONE, 0, '0, 1'b0));
    send_cmd(mk(FUNC_SPARE_LAST, 0, 0, KIND_NONE, 0, '0, 1'b0));
    drain();
    write_start(6'd63);
    send_cmd(mk(FUNC_RESTART, 0, 0, KIND_NONE, 0, '0, 1'b0));
    send_cmd(mk(FUNC_QUERY, 0, 0, KIND_NONE, 0, '0, 1'b0));

    // Random phases, each under its own start state
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      st = (ph == 1) ? 6'd0 : (ph == 3) ? 6'd63 : 6'($urandom_range(0, NST - 1));
      write_start(st);
      st_pool[0] = st;
      for (int i = 1; i < 8; i++) st_pool[i] = STATE_W'($urandom_range(0, NST - 1));
      for (int i = 0; i < 4; i++) begin
        sym_pool[i] = SYM_W'($urandom_range(0, 511));
        adr_pool[i] = $urandom;
      end
      for (int i = 0; i < 40; i++) send_cmd(rand_cmd());
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("Ran %0d commands over several start states; %0d results, %0d query addresses.",
             board.n_cmds, board.n_res, board.n_addr_res);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
